[design/wbc_pkg.sv]
// Shared types and constants of the weighted beam combiner.
package wbc_pkg;

  localparam int unsigned BeamW    = 2;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ProdW    = 33;
  localparam int unsigned AccW     = 48;
  localparam int unsigned FracW    = 15;
  localparam int unsigned OutW     = 24;
  localparam int unsigned NumParts = 4;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned ShW      = AccW - FracW;

  localparam logic [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  typedef struct packed {
    logic [BeamW-1:0]          beam;
    logic signed [SampleW-1:0] x_re;
    logic signed [SampleW-1:0] x_im;
    logic signed [SampleW-1:0] y_re;
    logic signed [SampleW-1:0] y_im;
    logic signed [SampleW-1:0] w_re;
    logic signed [SampleW-1:0] w_im;
    logic                      station_valid;
    logic                      sample_flagged;
    logic                      last_station;
  } in_item_t;

  typedef struct packed {
    logic [BeamW-1:0]                beam;
    logic                            station_valid;
    logic                            sample_flagged;
    logic                            last_station;
    logic [NumParts-1:0][ProdW-1:0]  part;
  } prod_t;

  typedef struct packed {
    logic [BeamW-1:0]               beam;
    logic                           any_valid;
    logic                           flag_seen;
    logic [NumParts-1:0][AccW-1:0]  sum;
  } fin_t;

endpackage

[design/weighted_beam_combiner_unit.sv]
// Top level of the weighted beam combiner: input register and stage wiring.
//
//   Channel  Direction  tdata (low bit up)                     tuser / tlast
//   s_axis   in         beam_index, x_re..y_im, w_re, w_im     valid, flagged / last
//   m_axis   out        out_beam, bx_re, bx_im, by_re, by_im   flagged, saturated / -
//
// One request is taken every clock cycle while no stage stalls; the multiply,
// accumulate and output stages each hold one register. A closing request's
// result passes the input, multiply, accumulate and output registers to m_axis.
// Reset clears all valid bits and the accumulators. A stalled output holds its
// result while earlier stages keep accepting requests until the pipeline fills.
module weighted_beam_combiner_unit
  import wbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // beam_index, x_re, x_im, y_re, y_im, w_re, w_im, zero padding
  input  logic [InDataW-1:0]  s_axis_tdata,
  // station_valid, sample_flagged
  input  logic [InUserW-1:0]  s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_beam, bx_re, bx_im, by_re, by_im, zero padding
  output logic [OutDataW-1:0] m_axis_tdata,
  // flagged, saturated
  output logic [OutUserW-1:0] m_axis_tuser
);

  in_item_t in_d, in_q;
  logic     in_v_q;
  logic     mult_ready, prod_valid, acc_ready, fin_valid, sat_ready;
  prod_t    prod;
  fin_t     fin;

  always_comb begin
    in_d.beam           = s_axis_tdata[BeamW-1:0];
    in_d.x_re           = s_axis_tdata[BeamW+SampleW-1:BeamW];
    in_d.x_im           = s_axis_tdata[BeamW+2*SampleW-1:BeamW+SampleW];
    in_d.y_re           = s_axis_tdata[BeamW+3*SampleW-1:BeamW+2*SampleW];
    in_d.y_im           = s_axis_tdata[BeamW+4*SampleW-1:BeamW+3*SampleW];
    in_d.w_re           = s_axis_tdata[BeamW+5*SampleW-1:BeamW+4*SampleW];
    in_d.w_im           = s_axis_tdata[BeamW+6*SampleW-1:BeamW+5*SampleW];
    in_d.station_valid  = s_axis_tuser[0];
    in_d.sample_flagged = s_axis_tuser[1];
    in_d.last_station   = s_axis_tlast;
  end

  assign s_axis_tready = !in_v_q || mult_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_d;
    end
  end

  wbc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .ready_o (mult_ready),
    .item_i  (in_q),
    .valid_o (prod_valid),
    .ready_i (acc_ready),
    .prod_o  (prod)
  );

  wbc_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (acc_ready),
    .prod_i  (prod),
    .valid_o (fin_valid),
    .ready_i (sat_ready),
    .fin_o   (fin)
  );

  wbc_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fin_valid),
    .ready_o (sat_ready),
    .fin_i   (fin),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser)
  );

endmodule

[design/wbc_mult.sv]
// Complex weight multiply stage: eight real products summed into four parts per request.
module wbc_mult
  import wbc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     ready_i,
  output prod_t    prod_o
);

  logic signed [2*SampleW-1:0] xrwr, xiwi, xrwi, xiwr, yrwr, yiwi, yrwi, yiwr;
  logic  v_q;
  prod_t prod_d, prod_q;
  logic  load;

  assign xrwr = item_i.x_re * item_i.w_re;
  assign xiwi = item_i.x_im * item_i.w_im;
  assign xrwi = item_i.x_re * item_i.w_im;
  assign xiwr = item_i.x_im * item_i.w_re;
  assign yrwr = item_i.y_re * item_i.w_re;
  assign yiwi = item_i.y_im * item_i.w_im;
  assign yrwi = item_i.y_re * item_i.w_im;
  assign yiwr = item_i.y_im * item_i.w_re;

  always_comb begin
    prod_d.beam           = item_i.beam;
    prod_d.station_valid  = item_i.station_valid;
    prod_d.sample_flagged = item_i.sample_flagged;
    prod_d.last_station   = item_i.last_station;
    prod_d.part[0] = {xrwr[2*SampleW-1], xrwr} - {xiwi[2*SampleW-1], xiwi};
    prod_d.part[1] = {xrwi[2*SampleW-1], xrwi} + {xiwr[2*SampleW-1], xiwr};
    prod_d.part[2] = {yrwr[2*SampleW-1], yrwr} - {yiwi[2*SampleW-1], yiwi};
    prod_d.part[3] = {yrwi[2*SampleW-1], yrwi} + {yiwr[2*SampleW-1], yiwr};
  end

  assign ready_o = !v_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = v_q;
  assign prod_o  = prod_q;

endmodule

[design/wbc_accum.sv]
// Per-polarisation accumulators and the register that holds a closed beam sample.
module wbc_accum
  import wbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  prod_t prod_i,
  output logic  valid_o,
  input  logic  ready_i,
  output fin_t  fin_o
);

  logic [NumParts-1:0][AccW-1:0] acc_q, sum;
  logic flag_q, any_q;
  logic fin_v_q;
  fin_t fin_q;
  logic fin_free, adv, close;

  always_comb begin
    for (int i = 0; i < NumParts; i++) begin
      if (prod_i.station_valid) begin
        sum[i] = acc_q[i] + {{(AccW-ProdW){prod_i.part[i][ProdW-1]}}, prod_i.part[i]};
      end else begin
        sum[i] = acc_q[i];
      end
    end
  end

  assign fin_free = !fin_v_q || ready_i;
  assign ready_o  = !prod_i.last_station || fin_free;
  assign adv      = valid_i && ready_o;
  assign close    = adv && prod_i.last_station;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      flag_q <= 1'b0;
      any_q  <= 1'b0;
    end else if (close) begin
      acc_q  <= '0;
      flag_q <= 1'b0;
      any_q  <= 1'b0;
    end else if (adv) begin
      acc_q  <= sum;
      flag_q <= flag_q || (prod_i.station_valid && prod_i.sample_flagged);
      any_q  <= any_q || prod_i.station_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (close) begin
      fin_v_q <= 1'b1;
    end else if (ready_i) begin
      fin_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      fin_q.beam      <= prod_i.beam;
      fin_q.any_valid <= any_q || prod_i.station_valid;
      fin_q.flag_seen <= flag_q || (prod_i.station_valid && prod_i.sample_flagged);
      fin_q.sum       <= sum;
    end
  end

  assign valid_o = fin_v_q;
  assign fin_o   = fin_q;

`ifndef SYNTHESIS
  a_clear_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |=> (acc_q == '0) && !any_q && !flag_q)
    else $error("Accumulators not cleared after a closing request.");

  a_idle_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (acc_q == '0))
    else $error("Accumulator non-zero although no valid station was seen.");

  a_flag_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |-> any_q)
    else $error("Flag recorded without a valid station.");

  a_fin_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v_q && !ready_i |=> fin_v_q && $stable(fin_q))
    else $error("Closed beam sample lost or changed while stalled.");
`endif

endmodule

[design/wbc_sat.sv]
// Output stage: shift, saturate (or zero a sample with no valid station) and register the finished beam sample.
module wbc_sat
  import wbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  fin_t                fin_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutDataW-1:0] data_o,
  output logic [OutUserW-1:0] user_o
);

  logic [NumParts-1:0][OutW-1:0] res;
  logic [NumParts-1:0]           clip;
  logic [ShW-1:0]                sh [NumParts];
  logic                          v_q;
  logic [OutDataW-1:0]           data_d, data_q;
  logic [OutUserW-1:0]           user_d, user_q;

  always_comb begin
    for (int i = 0; i < NumParts; i++) begin
      sh[i]   = fin_i.sum[i][AccW-1:FracW];
      clip[i] = !((&sh[i][ShW-1:OutW-1]) || !(|sh[i][ShW-1:OutW-1]));
      if (!fin_i.any_valid) begin
        res[i] = '0;
      end else if (clip[i]) begin
        res[i] = sh[i][ShW-1] ? OutMin : OutMax;
      end else begin
        res[i] = sh[i][OutW-1:0];
      end
    end
    data_d = {{(OutDataW-BeamW-NumParts*OutW){1'b0}}, res, fin_i.beam};
    user_d = {fin_i.any_valid && (|clip), !fin_i.any_valid || fin_i.flag_seen};
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

endmodule

[bench/tb_weighted_beam_combiner_unit.sv]
// Self-checking testbench for the weighted beam combiner with a predictor of beam sums.
`timescale 1ns / 1ps

module tb_weighted_beam_combiner_unit
  import wbc_pkg::*;
();

  typedef struct packed {
    logic [BeamW-1:0] beam;
    logic [OutW-1:0]  bx_re;
    logic [OutW-1:0]  bx_im;
    logic [OutW-1:0]  by_re;
    logic [OutW-1:0]  by_im;
    logic             flagged;
    logic             saturated;
  } beam_sum_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  in_item_t  stations_pending[$];
  beam_sum_t beams_due[$];
  in_item_t  offered;
  bit        in_taken;
  int        n_in;
  int        n_total;
  int        n_errors;
  int        hold_cnt;
  bit        hold_done;

  logic [AccW-1:0] acc_xr, acc_xi, acc_yr, acc_yi;
  logic            flag_seen, any_valid;

  weighted_beam_combiner_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint sx(input logic [SampleW-1:0] v);
    return longint'($signed(v));
  endfunction

  // Floor division by 2^15 followed by clipping; the top bit reports a clip.
  function automatic logic [OutW:0] scale_part(input logic [AccW-1:0] acc);
    longint q;
    q = longint'($signed(acc)) >>> FracW;
    if (q > longint'($signed(OutMax))) return {1'b1, OutMax};
    if (q < longint'($signed(OutMin))) return {1'b1, OutMin};
    return {1'b0, q[OutW-1:0]};
  endfunction

  task automatic combine_station(input in_item_t s);
    beam_sum_t       r;
    logic [OutW:0]   q0, q1, q2, q3;
    if (s.station_valid) begin
      acc_xr    = acc_xr + AccW'(sx(s.x_re) * sx(s.w_re) - sx(s.x_im) * sx(s.w_im));
      acc_xi    = acc_xi + AccW'(sx(s.x_re) * sx(s.w_im) + sx(s.x_im) * sx(s.w_re));
      acc_yr    = acc_yr + AccW'(sx(s.y_re) * sx(s.w_re) - sx(s.y_im) * sx(s.w_im));
      acc_yi    = acc_yi + AccW'(sx(s.y_re) * sx(s.w_im) + sx(s.y_im) * sx(s.w_re));
      flag_seen = flag_seen | s.sample_flagged;
      any_valid = 1'b1;
    end
    if (s.last_station) begin
      r.beam = s.beam;
      if (any_valid) begin
        q0 = scale_part(acc_xr);
        q1 = scale_part(acc_xi);
        q2 = scale_part(acc_yr);
        q3 = scale_part(acc_yi);
        r.bx_re     = q0[OutW-1:0];
        r.bx_im     = q1[OutW-1:0];
        r.by_re     = q2[OutW-1:0];
        r.by_im     = q3[OutW-1:0];
        r.flagged   = flag_seen;
        r.saturated = q0[OutW] | q1[OutW] | q2[OutW] | q3[OutW];
      end else begin
        r.bx_re     = '0;
        r.bx_im     = '0;
        r.by_re     = '0;
        r.by_im     = '0;
        r.flagged   = 1'b1;
        r.saturated = 1'b0;
      end
      beams_due.insert(beams_due.size(), r);
      acc_xr    = '0;
      acc_xi    = '0;
      acc_yr    = '0;
      acc_yi    = '0;
      flag_seen = 1'b0;
      any_valid = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [OutW-1:0] want,
                             input logic [OutW-1:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int phase_now();
    if (n_in < n_total / 3) return 0;
    if (n_in < 2 * n_total / 3) return 1;
    return 2;
  endfunction

  function automatic logic [SampleW-1:0] rand_part();
    logic [SampleW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'($urandom_range(0, 6)) - 16'd3;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic push_station(input logic [BeamW-1:0] beam,
                              input logic [SampleW-1:0] xr, xi, yr, yi, wr, wi,
                              input logic v, f, l);
    in_item_t s;
    s.beam           = beam;
    s.x_re           = xr;
    s.x_im           = xi;
    s.y_re           = yr;
    s.y_im           = yi;
    s.w_re           = wr;
    s.w_im           = wi;
    s.station_valid  = v;
    s.sample_flagged = f;
    s.last_station   = l;
    stations_pending.insert(stations_pending.size(), s);
  endtask

  // Short run with random content; now and then every station is left out.
  task automatic push_short_run();
    int len;
    bit none_valid;
    len        = $urandom_range(1, 6);
    none_valid = roll(10);
    for (int i = 0; i < len; i++) begin
      push_station(BeamW'($urandom), rand_part(), rand_part(), rand_part(), rand_part(),
                   rand_part(), rand_part(), none_valid ? 1'b0 : roll(80), roll(15),
                   i == len - 1);
    end
  endtask

  // Long run of near full-scale products that drives the sums past 24 bits.
  task automatic push_long_run(input bit negative);
    int len;
    logic [SampleW-1:0] xr;
    len = $urandom_range(140, 170);
    xr  = negative ? 16'h7FFF : 16'h8000;
    for (int i = 0; i < len; i++) begin
      push_station(BeamW'($urandom), xr - 16'($urandom_range(0, 2)),
                   16'h8000 + 16'($urandom_range(0, 2)), rand_part(), rand_part(),
                   16'h8000 + 16'($urandom_range(0, 2)),
                   (negative ? 16'h8000 : 16'h7FFF) - 16'($urandom_range(0, 2)),
                   !roll(3), roll(5), i == len - 1);
    end
  endtask

  // Sender: a new request is offered once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (stations_pending.size() != 0 && !roll(phase_now() == 0 ? 10 :
                                                phase_now() == 1 ? 70 : 0)) begin
        offered = stations_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, offered.w_im, offered.w_re, offered.y_im, offered.y_re,
                          offered.x_im, offered.x_re, offered.beam};
        s_axis_tuser  <= {offered.sample_flagged, offered.station_valid};
        s_axis_tlast  <= offered.last_station;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, including one long hold-off so that the pipeline fills up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (!hold_done && n_in >= 60) begin
      hold_done     <= 1'b1;
      hold_cnt      <= 80;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !roll(phase_now() == 0 ? 70 : phase_now() == 1 ? 10 : 0);
    end
  end

  always @(posedge clk_i) begin
    beam_sum_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (beams_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beam sample, actual data %h user %b", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        want = beams_due.pop_front();
        check_field("out_beam", OutW'(want.beam), OutW'(m_axis_tdata[1:0]));
        check_field("bx_re", want.bx_re, m_axis_tdata[25:2]);
        check_field("bx_im", want.bx_im, m_axis_tdata[49:26]);
        check_field("by_re", want.by_re, m_axis_tdata[73:50]);
        check_field("by_im", want.by_im, m_axis_tdata[97:74]);
        check_field("flagged", OutW'(want.flagged), OutW'(m_axis_tuser[0]));
        check_field("saturated", OutW'(want.saturated), OutW'(m_axis_tuser[1]));
      end
    end
    in_taken = s_axis_tvalid && s_axis_tready;
    if (in_taken) begin
      combine_station(offered);
      n_in++;
    end
  end

  initial begin
    bit pos_done;
    bit neg_done;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    in_taken      = 1'b0;
    n_in          = 0;
    n_errors      = 0;
    hold_cnt      = 0;
    hold_done     = 1'b0;
    pos_done      = 1'b0;
    neg_done      = 1'b0;
    n_total       = 1;
    acc_xr        = '0;
    acc_xi        = '0;
    acc_yr        = '0;
    acc_yi        = '0;
    flag_seen     = 1'b0;
    any_valid     = 1'b0;

    // Full-scale negative and positive parts, single-station runs.
    push_station(2'd3, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 1'b1, 1'b0, 1'b1);
    push_station(2'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 1'b1, 1'b1, 1'b1);
    push_station(2'd1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                 1'b1, 1'b0, 1'b1);
    // No valid station at all, with a flagged sample that must be ignored.
    push_station(2'd2, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h4000, 16'h4000,
                 1'b0, 1'b1, 1'b1);
    // A flag on an ignored station does not reach the result.
    push_station(2'd1, 16'd100, 16'd200, 16'd300, 16'd400, 16'h4000, 16'h0000,
                 1'b1, 1'b0, 1'b0);
    push_station(2'd2, 16'd5, 16'd6, 16'd7, 16'd8, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 1'b0);
    push_station(2'd3, 16'd9, 16'd10, 16'd11, 16'd12, 16'h2000, 16'h2000,
                 1'b0, 1'b0, 1'b1);
    // Truncation toward minus infinity on tiny sums of both signs.
    push_station(2'd0, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0000,
                 1'b1, 1'b0, 1'b1);
    push_station(2'd1, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h0001,
                 1'b1, 1'b0, 1'b1);
    // Products that cancel and a multi-station run with a flagged member.
    push_station(2'd2, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF, 16'h8000, 16'h8000,
                 1'b1, 1'b0, 1'b0);
    push_station(2'd2, 16'h7FFF, 16'h8000, 16'h0100, 16'h0100, 16'h7FFF, 16'h8000,
                 1'b1, 1'b1, 1'b0);
    push_station(2'd0, 16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h7FFF, 16'h0000,
                 1'b1, 1'b0, 1'b0);
    push_station(2'd3, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0000, 16'h7FFF,
                 1'b1, 1'b0, 1'b1);
    for (int i = 0; i < 4; i++) begin
      push_station(BeamW'(i), rand_part(), rand_part(), rand_part(), rand_part(),
                   rand_part(), rand_part(), 1'b1, 1'b0, i == 3);
    end

    while (stations_pending.size() < 750) begin
      if (!pos_done && stations_pending.size() > 250) begin
        push_long_run(1'b0);
        pos_done = 1'b1;
      end else if (!neg_done && stations_pending.size() > 480) begin
        push_long_run(1'b1);
        neg_done = 1'b1;
      end else begin
        push_short_run();
      end
    end
    n_total = stations_pending.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (n_in < n_total || beams_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
